// File: design/ksort_pkg.sv
// Shared types and constants for the keyed insertion sorter.
`timescale 1ns / 1ps

package ksort_pkg;

    // Default number of records the sorter holds.
    localparam int DEF_CAPACITY = 32;

    localparam int KEY_W  = 32;
    localparam int TAG_W  = 16;
    localparam int TOL_W  = 31;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_ASCENDING = 1'b0;
    localparam logic REG_TOLERANCE = 1'b1;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } rec_t;

    // Control and data broadcast from the top level to every cell.
    typedef struct packed {
        logic             insert;
        logic             drain;
        logic             ascending;
        logic [TOL_W-1:0] tolerance;
        rec_t             fresh;
    } cell_bcast_t;

endpackage

// File: design/ksort_cell.sv
// One compare-and-shift cell of the sorter chain.
`timescale 1ns / 1ps

module ksort_cell
    import ksort_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_bcast_t bcast,
    input  logic        lo_valid,
    input  rec_t        lo_rec,
    input  logic        lo_run,
    input  logic        hi_valid,
    input  rec_t        hi_rec,
    input  logic        hi_run,
    output logic        valid,
    output rec_t        rec,
    output logic        run
);

    logic        valid_reg;
    logic        valid_next;
    rec_t        rec_reg;
    rec_t        rec_next;
    logic signed [KEY_W:0] diff;
    logic        moves;

    // A stored key moves past the new one when it lies beyond it by more
    // than the tolerance. The difference is kept one bit wider so it is exact.
    always_comb
    begin
        if (bcast.ascending)
        begin
            diff = {rec_reg.key[KEY_W-1], rec_reg.key}
                 - {bcast.fresh.key[KEY_W-1], bcast.fresh.key};
        end
        else
        begin
            diff = {bcast.fresh.key[KEY_W-1], bcast.fresh.key}
                 - {rec_reg.key[KEY_W-1], rec_reg.key};
        end
        moves = diff > $signed({2'b00, bcast.tolerance});
    end

    // An empty cell never stops the scan.
    assign run = (moves | ~valid_reg) & hi_run;

    always_comb
    begin
        valid_next = valid_reg;
        rec_next   = rec_reg;
        priority if (bcast.drain)
        begin
            valid_next = hi_valid;
            rec_next   = hi_rec;
        end
        else if (bcast.insert)
        begin
            priority if (lo_run)
            begin
                valid_next = lo_valid;
                rec_next   = lo_rec;
            end
            else if (run)
            begin
                valid_next = 1'b1;
                rec_next   = bcast.fresh;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign valid = valid_reg;
    assign rec   = rec_reg;

endmodule

// File: design/ksort_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module ksort_regs
    import ksort_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic              ascending,
    output logic [TOL_W-1:0]  tolerance
);

    logic             ascending_reg;
    logic             ascending_next;
    logic [TOL_W-1:0] tolerance_reg;
    logic [TOL_W-1:0] tolerance_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb
    begin
        ascending_next = ascending_reg;
        tolerance_next = tolerance_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_ASCENDING: ascending_next = pwdata[0];
                REG_TOLERANCE: tolerance_next = pwdata[TOL_W-1:0];
                default:       ascending_next = ascending_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ascending_reg <= 1'b1;
            tolerance_reg <= '0;
        end
        else
        begin
            ascending_reg <= ascending_next;
            tolerance_reg <= tolerance_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ASCENDING: prdata = {{(DATA_W-1){1'b0}}, ascending_reg};
            REG_TOLERANCE: prdata = {{(DATA_W-TOL_W){1'b0}}, tolerance_reg};
            default:       prdata = '0;
        endcase
    end

    assign ascending = ascending_reg;
    assign tolerance = tolerance_reg;

endmodule

// File: design/keyed_insertion_sorter.sv
// Top level of the keyed insertion sorter: cell chain, intake and drain control.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Word
// input     in         in_valid/in_ready    key, tag, last
// result    out        out_valid/out_ready  key_res, tag_res, last_res, overflow
// config    in         psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// Intake takes one word per cycle while no drain is open; each word is
// compared against every cell of the chain in the same cycle and the chain
// shifts to open its slot. After a word marked last, the chain drains one
// word per cycle from its bottom cell, and intake is closed until the
// drain ends. Reset empties the chain at once (valid bits only).
// A stalled result holds the drain; the output register lets the next set
// start while the final result of a run still waits.

module keyed_insertion_sorter
    import ksort_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Input channel.
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [KEY_W-1:0] key,
    input  logic [TAG_W-1:0]        tag,
    input  logic                    last,
    // Result channel.
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [KEY_W-1:0] key_res,
    output logic [TAG_W-1:0]        tag_res,
    output logic                    last_res,
    output logic                    overflow,
    // Configuration port.
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    logic             ascending;
    logic [TOL_W-1:0] tolerance;

    ksort_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .ascending (ascending),
        .tolerance (tolerance)
    );

    // Cell chain. Cell 0 holds the first record of the sorted order; cells
    // fill from the bottom, so the top cell being valid means the store is full.
    logic        cell_valid [CAPACITY];
    rec_t        cell_rec   [CAPACITY];
    logic        cell_run   [CAPACITY];
    cell_bcast_t bcast;

    logic drain_reg;
    logic drain_next;
    logic dropped_reg;
    logic dropped_next;
    logic run_ovf_reg;
    logic run_ovf_next;
    logic out_valid_reg;
    logic out_valid_next;
    rec_t out_rec_reg;
    rec_t out_rec_next;
    logic out_last_reg;
    logic out_last_next;
    logic out_ovf_reg;
    logic out_ovf_next;

    logic in_fire;
    logic full;
    logic drain_step;

    assign full       = cell_valid[CAPACITY-1];
    assign in_ready   = ~drain_reg;
    assign in_fire    = in_valid & in_ready;
    // The chain shifts down only when the output register can take a word.
    assign drain_step = drain_reg & (~out_valid_reg | out_ready);

    always_comb
    begin
        bcast.insert    = in_fire & ~full;
        bcast.drain     = drain_step;
        bcast.ascending = ascending;
        bcast.tolerance = tolerance;
        bcast.fresh.key = key;
        bcast.fresh.tag = tag;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic lo_valid;
        rec_t lo_rec;
        logic lo_run;
        logic hi_valid;
        rec_t hi_rec;
        logic hi_run;

        if (i == 0)
        begin : g_bottom
            assign lo_valid = 1'b0;
            assign lo_rec   = '0;
            assign lo_run   = 1'b0;
        end
        else
        begin : g_lower
            assign lo_valid = cell_valid[i-1];
            assign lo_rec   = cell_rec[i-1];
            assign lo_run   = cell_run[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_top
            assign hi_valid = 1'b0;
            assign hi_rec   = '0;
            assign hi_run   = 1'b1;
        end
        else
        begin : g_upper
            assign hi_valid = cell_valid[i+1];
            assign hi_rec   = cell_rec[i+1];
            assign hi_run   = cell_run[i+1];
        end

        ksort_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bcast    (bcast),
            .lo_valid (lo_valid),
            .lo_rec   (lo_rec),
            .lo_run   (lo_run),
            .hi_valid (hi_valid),
            .hi_rec   (hi_rec),
            .hi_run   (hi_run),
            .valid    (cell_valid[i]),
            .rec      (cell_rec[i]),
            .run      (cell_run[i])
        );
    end

    // Intake and drain control. A word marked last opens the drain and
    // freezes the overflow flag for that run; a dropped last word counts too.
    always_comb
    begin
        drain_next     = drain_reg;
        dropped_next   = dropped_reg;
        run_ovf_next   = run_ovf_reg;
        out_valid_next = out_valid_reg;
        out_rec_next   = out_rec_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        if (in_fire)
        begin
            if (last)
            begin
                drain_next   = 1'b1;
                run_ovf_next = dropped_reg | full;
                dropped_next = 1'b0;
            end
            else if (full)
            begin
                dropped_next = 1'b1;
            end
        end

        if (drain_step)
        begin
            out_valid_next = 1'b1;
            out_rec_next   = cell_rec[0];
            out_last_next  = ~cell_valid[1];
            out_ovf_next   = run_ovf_reg;
            // The bottom cell is the last stored word when the one above is empty.
            if (!cell_valid[1])
            begin
                drain_next = 1'b0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            run_ovf_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            drain_reg     <= drain_next;
            dropped_reg   <= dropped_next;
            run_ovf_reg   <= run_ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rec_reg  <= out_rec_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign out_valid = out_valid_reg;
    assign key_res   = out_rec_reg.key;
    assign tag_res   = out_rec_reg.tag;
    assign last_res  = out_last_reg;
    assign overflow  = out_ovf_reg;

endmodule
